// ===== rtl/core/rmap_tt_pkg.sv =====
`default_nettype none

package rmap_tt_pkg;

    // Field widths
    localparam int unsigned STATUS_W = 5;
    localparam int unsigned TID_W    = 16;
    localparam int unsigned LEN_W    = 24;

    // Item modes
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_POLL  = 2'd2;
    localparam logic [1:0] MODE_LINK  = 2'd3;

    // Link reset outcomes
    localparam logic [1:0] LINK_RUNNING     = 2'd0;
    localparam logic [1:0] LINK_INIT_FAILED = 2'd1;

    // Transmit check results
    localparam logic [1:0] TX_BUSY = 2'd0;
    localparam logic [1:0] TX_DONE = 2'd1;

    // Reply packet kinds
    localparam logic [1:0] KIND_WRITE_REPLY = 2'd1;
    localparam logic [1:0] KIND_READ_REPLY  = 2'd2;

    // Status codes
    localparam logic [4:0] ST_OK             = 5'd0;
    localparam logic [4:0] ST_SENDING        = 5'd1;
    localparam logic [4:0] ST_RECEIVING      = 5'd2;
    localparam logic [4:0] ST_TX_LINK        = 5'd3;
    localparam logic [4:0] ST_RX_EEP         = 5'd4;
    localparam logic [4:0] ST_RX_TRUNC       = 5'd5;
    localparam logic [4:0] ST_RX_DCRC        = 5'd6;
    localparam logic [4:0] ST_RX_HCRC        = 5'd7;
    localparam logic [4:0] ST_UNPARSABLE     = 5'd8;
    localparam logic [4:0] ST_UNEXPECTED     = 5'd9;
    localparam logic [4:0] ST_TID_MISMATCH   = 5'd10;
    localparam logic [4:0] ST_REMOTE_LOW     = 5'd11;
    localparam logic [4:0] ST_REMOTE_HIGH    = 5'd18;
    localparam logic [4:0] ST_REMOTE_UNKNOWN = 5'd22;
    localparam logic [4:0] ST_LEN_MISMATCH   = 5'd23;
    localparam logic [4:0] ST_INIT           = 5'd24;
    localparam logic [4:0] ST_DISCONNECTED   = 5'd25;

    // Remote status byte ranges that map to their own codes
    localparam logic [7:0] RSTAT_LOW_FIRST  = 8'd1;
    localparam logic [7:0] RSTAT_LOW_LAST   = 8'd7;
    localparam logic [7:0] RSTAT_HIGH_FIRST = 8'd9;
    localparam logic [7:0] RSTAT_HIGH_LAST  = 8'd12;

    // One input item
    typedef struct packed {
        logic [1:0]       mode;
        logic             request_ack;
        logic [LEN_W-1:0] request_len;
        logic [1:0]       link_result;
        logic [1:0]       tx_state;
        logic             rx_ended;
        logic [3:0]       rx_error_flags;
        logic             reply_parsed;
        logic [1:0]       reply_kind;
        logic [TID_W-1:0] reply_tid;
        logic [7:0]       reply_status;
        logic [LEN_W-1:0] reply_len;
    } item_t;

    // Tracked command state
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TID_W-1:0]    tid;
        logic                is_read;
        logic                wants_ack;
        logic [LEN_W-1:0]    expected_len;
    } cmd_state_t;

    // One result item
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TID_W-1:0]    tid;
    } result_t;

    // Map a link reset outcome to a status code
    function automatic logic [4:0] link_outcome(input logic [1:0] link);
        logic [4:0] code;
        if (link == LINK_RUNNING) begin
            code = ST_OK;
        end else if (link == LINK_INIT_FAILED) begin
            code = ST_INIT;
        end else begin
            code = ST_DISCONNECTED;
        end
        return code;
    endfunction

    // Map a remote status byte to a status code (skips the unused value eight)
    function automatic logic [4:0] remote_map(input logic [7:0] rstat);
        logic [4:0] code;
        if (rstat >= RSTAT_LOW_FIRST && rstat <= RSTAT_LOW_LAST) begin
            code = ST_REMOTE_LOW + 5'(rstat[3:0] - RSTAT_LOW_FIRST[3:0]);
        end else if (rstat >= RSTAT_HIGH_FIRST && rstat <= RSTAT_HIGH_LAST) begin
            code = ST_REMOTE_HIGH + 5'(rstat[3:0] - RSTAT_HIGH_FIRST[3:0]);
        end else begin
            code = ST_REMOTE_UNKNOWN;
        end
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rmap_transaction_tracker.sv =====
// Path: an accepted item is held in the input register, then its result is registered
//   in the result register; an output stall can hold it in either register.
// Throughput: one item per cycle unless out_stall backs up both stages.
// Reset: both pipeline stages empty, status disconnected, transaction id zero,
//   command type, ack request and expected length cleared.
`default_nettype none

module rmap_transaction_tracker #(
    parameter int unsigned TID_MAX = 65535
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire  [1:0]  mode,
    input  wire         request_ack,
    input  wire  [23:0] request_len,
    input  wire  [1:0]  link_result,
    input  wire  [1:0]  tx_state,
    input  wire         rx_ended,
    input  wire  [3:0]  rx_error_flags,
    input  wire         reply_parsed,
    input  wire  [1:0]  reply_kind,
    input  wire  [15:0] reply_tid,
    input  wire  [7:0]  reply_status,
    input  wire  [23:0] reply_len,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [4:0]  status,
    output logic [15:0] current_tid
);

    logic                    in_valid_reg;
    rmap_tt_pkg::item_t      item_reg;
    logic                    out_valid_reg;
    rmap_tt_pkg::result_t    result_reg;
    rmap_tt_pkg::result_t    result_next;
    rmap_tt_pkg::cmd_state_t state;
    logic                    out_ready;
    logic                    fire;

    // Result register can take a new item when empty or being drained
    assign out_ready = !out_valid_reg || !out_stall;
    assign fire      = in_valid_reg && out_ready;
    assign in_stall  = in_valid_reg && !out_ready;

    // Hold the input item until it moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (!in_stall) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall) begin
            item_reg.mode           <= mode;
            item_reg.request_ack    <= request_ack;
            item_reg.request_len    <= request_len;
            item_reg.link_result    <= link_result;
            item_reg.tx_state       <= tx_state;
            item_reg.rx_ended       <= rx_ended;
            item_reg.rx_error_flags <= rx_error_flags;
            item_reg.reply_parsed   <= reply_parsed;
            item_reg.reply_kind     <= reply_kind;
            item_reg.reply_tid      <= reply_tid;
            item_reg.reply_status   <= reply_status;
            item_reg.reply_len      <= reply_len;
        end
    end

    rmap_tt_core #(
        .TID_MAX (TID_MAX)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_reg),
        .state  (state),
        .result (result_next)
    );

    // Advance the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire) begin
            result_reg <= result_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = result_reg.status;
    assign current_tid = result_reg.tid;

    // Input stage only stalls when the result stage is full and blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall))
        else $error("input stalled while result stage free");

    // An item leaving the input stage always shows up as a result
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("item lost between stages");

    // Transaction id only moves when an item is processed
    assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(state.tid))
        else $error("transaction id changed without an item");

    // Tracked status always holds a defined code
    assert property (@(posedge clk) disable iff (!rst_n)
        state.status <= rmap_tt_pkg::ST_DISCONNECTED)
        else $error("tracked status out of range");

endmodule

`default_nettype wire

// ===== rtl/core/rmap_tt_poll.sv =====
`default_nettype none

module rmap_tt_poll (
    input  wire rmap_tt_pkg::cmd_state_t state,
    input  wire rmap_tt_pkg::item_t      item,
    output logic [rmap_tt_pkg::STATUS_W-1:0] poll_status
);

    logic [rmap_tt_pkg::STATUS_W-1:0] after_tx;
    logic                             kind_ok;

    // Resolve the transmit phase
    always_comb
    begin
        after_tx = state.status;
        if (state.status == rmap_tt_pkg::ST_SENDING) begin
            case (item.tx_state)
                rmap_tt_pkg::TX_BUSY: after_tx = rmap_tt_pkg::ST_SENDING;
                rmap_tt_pkg::TX_DONE: after_tx = state.wants_ack ? rmap_tt_pkg::ST_RECEIVING
                                                                 : rmap_tt_pkg::ST_OK;
                default:              after_tx = rmap_tt_pkg::ST_TX_LINK;
            endcase
        end
    end

    // Reply kind must match the command type
    assign kind_ok = (item.reply_kind == rmap_tt_pkg::KIND_WRITE_REPLY && !state.is_read) ||
                     (item.reply_kind == rmap_tt_pkg::KIND_READ_REPLY && state.is_read);

    // Resolve the receive phase in priority order
    always_comb
    begin
        poll_status = after_tx;
        if (after_tx == rmap_tt_pkg::ST_RECEIVING) begin
            if (!item.rx_ended) begin
                poll_status = rmap_tt_pkg::ST_RECEIVING;
            end else if (item.rx_error_flags[0]) begin
                poll_status = rmap_tt_pkg::ST_RX_EEP;
            end else if (item.rx_error_flags[1]) begin
                poll_status = rmap_tt_pkg::ST_RX_TRUNC;
            end else if (item.rx_error_flags[2]) begin
                poll_status = rmap_tt_pkg::ST_RX_DCRC;
            end else if (item.rx_error_flags[3]) begin
                poll_status = rmap_tt_pkg::ST_RX_HCRC;
            end else if (!item.reply_parsed) begin
                poll_status = rmap_tt_pkg::ST_UNPARSABLE;
            end else if (!kind_ok) begin
                poll_status = rmap_tt_pkg::ST_UNEXPECTED;
            end else if (item.reply_tid != state.tid) begin
                poll_status = rmap_tt_pkg::ST_TID_MISMATCH;
            end else if (item.reply_status != 8'd0) begin
                poll_status = rmap_tt_pkg::remote_map(item.reply_status);
            end else if (state.is_read && item.reply_len != state.expected_len) begin
                poll_status = rmap_tt_pkg::ST_LEN_MISMATCH;
            end else begin
                poll_status = rmap_tt_pkg::ST_OK;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rmap_tt_core.sv =====
`default_nettype none

module rmap_tt_core #(
    parameter int unsigned TID_MAX = 65535
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          fire,
    input  wire rmap_tt_pkg::item_t      item,
    output rmap_tt_pkg::cmd_state_t      state,
    output rmap_tt_pkg::result_t         result
);

    rmap_tt_pkg::cmd_state_t          state_reg;
    rmap_tt_pkg::cmd_state_t          state_next;
    logic [rmap_tt_pkg::STATUS_W-1:0] poll_status;
    logic [rmap_tt_pkg::STATUS_W-1:0] pre_issue;
    logic [rmap_tt_pkg::STATUS_W-1:0] result_status;

    rmap_tt_poll u_poll (
        .state       (state_reg),
        .item        (item),
        .poll_status (poll_status)
    );

    // Apply link outcome first when the tracked status is not ok (failed or still in progress)
    assign pre_issue = (state_reg.status == rmap_tt_pkg::ST_OK)
                     ? rmap_tt_pkg::ST_OK
                     : rmap_tt_pkg::link_outcome(item.link_result);

    // Decide next state and the answer for this item
    always_comb
    begin
        state_next    = state_reg;
        result_status = state_reg.status;
        case (item.mode)
            rmap_tt_pkg::MODE_WRITE, rmap_tt_pkg::MODE_READ:
            begin
                if (pre_issue != rmap_tt_pkg::ST_OK) begin
                    state_next.status = pre_issue;
                    result_status     = pre_issue;
                end else begin
                    state_next.tid = (state_reg.tid == rmap_tt_pkg::TID_W'(TID_MAX))
                                   ? '0 : state_reg.tid + 1'b1;
                    state_next.is_read      = (item.mode == rmap_tt_pkg::MODE_READ);
                    state_next.wants_ack    = (item.mode == rmap_tt_pkg::MODE_READ) ||
                                              item.request_ack;
                    state_next.expected_len = item.request_len;
                    state_next.status       = rmap_tt_pkg::ST_SENDING;
                    result_status           = rmap_tt_pkg::ST_OK;
                end
            end
            rmap_tt_pkg::MODE_POLL:
            begin
                state_next.status = poll_status;
                result_status     = poll_status;
            end
            default:
            begin
                state_next.status = rmap_tt_pkg::link_outcome(item.link_result);
                result_status     = state_next.status;
            end
        endcase
    end

    // Hold tracked state, advance only when an item passes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg.status       <= rmap_tt_pkg::ST_DISCONNECTED;
            state_reg.tid          <= '0;
            state_reg.is_read      <= 1'b0;
            state_reg.wants_ack    <= 1'b0;
            state_reg.expected_len <= '0;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    assign state         = state_reg;
    assign result.status = result_status;
    assign result.tid    = state_next.tid;

endmodule

`default_nettype wire

// ===== tb/rmap_tt_checker.sv =====
`default_nettype none

module rmap_tt_checker
    import rmap_tt_pkg::*;
#(
    parameter int unsigned TID_MAX = 65535
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              in_valid,
    input  wire              in_stall,
    input  wire item_t       req,
    input  wire              out_valid,
    input  wire              out_stall,
    input  wire  [4:0]       status,
    input  wire  [15:0]      current_tid,
    output int               fail_count,
    output int               outstanding,
    output logic [15:0]      model_tid
);
    timeunit 1ns;
    timeprecision 1ps;

    // Tracked command, mirrored from the item stream
    logic [STATUS_W-1:0] trk_status;
    logic [TID_W-1:0]    trk_tid;
    logic                trk_is_read;
    logic                trk_wants_ack;
    logic [LEN_W-1:0]    trk_len;

    // Answers still owed by the block, oldest first
    result_t status_answers[$];
    result_t want;

    // Map the link reset outcome onto a status code
    function automatic logic [4:0] link_code(input logic [1:0] link);
        case (link)
            LINK_RUNNING:     return ST_OK;
            LINK_INIT_FAILED: return ST_INIT;
            default:          return ST_DISCONNECTED;
        endcase
    endfunction

    // Remote status bytes one to seven and nine to twelve get codes of their own
    function automatic logic [4:0] remote_code(input logic [7:0] rstat);
        if (rstat >= RSTAT_LOW_FIRST && rstat <= RSTAT_LOW_LAST)
        begin
            return ST_REMOTE_LOW + 5'(rstat - RSTAT_LOW_FIRST);
        end
        if (rstat >= RSTAT_HIGH_FIRST && rstat <= RSTAT_HIGH_LAST)
        begin
            return ST_REMOTE_HIGH + 5'(rstat - RSTAT_HIGH_FIRST);
        end
        return ST_REMOTE_UNKNOWN;
    endfunction

    // Judge a reply while receiving: local flags first, then header, then remote, then read length
    function automatic logic [4:0] reply_code(input item_t it);
        logic kind_ok;
        kind_ok = trk_is_read ? (it.reply_kind == KIND_READ_REPLY)
                              : (it.reply_kind == KIND_WRITE_REPLY);
        if (!it.rx_ended)
        begin
            return ST_RECEIVING;
        end
        if (it.rx_error_flags[0]) return ST_RX_EEP;
        if (it.rx_error_flags[1]) return ST_RX_TRUNC;
        if (it.rx_error_flags[2]) return ST_RX_DCRC;
        if (it.rx_error_flags[3]) return ST_RX_HCRC;
        if (!it.reply_parsed) return ST_UNPARSABLE;
        if (!kind_ok) return ST_UNEXPECTED;
        if (it.reply_tid != trk_tid) return ST_TID_MISMATCH;
        if (|it.reply_status) return remote_code(it.reply_status);
        if (trk_is_read && it.reply_len != trk_len) return ST_LEN_MISMATCH;
        return ST_OK;
    endfunction

    // Advance the tracked command by one item and return the status it answers
    function automatic logic [4:0] track_item(input item_t it);
        logic [4:0] answer;
        case (it.mode)
            MODE_WRITE, MODE_READ:
            begin
                if (trk_status != ST_OK)
                begin
                    trk_status = link_code(it.link_result);
                end
                if (trk_status != ST_OK)
                begin
                    answer = trk_status;
                end
                else
                begin
                    trk_tid       = (trk_tid == 16'(TID_MAX)) ? '0 : trk_tid + 16'd1;
                    trk_is_read   = (it.mode == MODE_READ);
                    trk_wants_ack = trk_is_read || it.request_ack;
                    trk_len       = it.request_len;
                    trk_status    = ST_SENDING;
                    answer        = ST_OK;
                end
            end
            MODE_POLL:
            begin
                // Transmit and receive may both resolve in the same poll
                if (trk_status == ST_SENDING && it.tx_state != TX_BUSY)
                begin
                    if (it.tx_state == TX_DONE)
                    begin
                        trk_status = trk_wants_ack ? ST_RECEIVING : ST_OK;
                    end
                    else
                    begin
                        trk_status = ST_TX_LINK;
                    end
                end
                if (trk_status == ST_RECEIVING)
                begin
                    trk_status = reply_code(it);
                end
                answer = trk_status;
            end
            default:
            begin
                trk_status = link_code(it.link_result);
                answer     = trk_status;
            end
        endcase
        return answer;
    endfunction

    // Check results against the oldest answer, then predict the new item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trk_status    = ST_DISCONNECTED;
            trk_tid       = '0;
            trk_is_read   = 1'b0;
            trk_wants_ack = 1'b0;
            trk_len       = '0;
            status_answers.delete();
            fail_count    = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (status_answers.size() == 0)
                begin
                    fail_count++;
                    $error("result with nothing pending: status %0d, current_tid %0d",
                           status, current_tid);
                end
                else
                begin
                    want = status_answers.pop_front();
                    if (status !== want.status)
                    begin
                        fail_count++;
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, status);
                    end
                    if (current_tid !== want.tid)
                    begin
                        fail_count++;
                        $error("current_tid mismatch: expected %0d, actual %0d",
                               want.tid, current_tid);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                want.status = track_item(req);
                want.tid    = trk_tid;
                status_answers.push_back(want);
            end
        end
        outstanding = status_answers.size();
        model_tid   = trk_tid;
    end

endmodule

`default_nettype wire

// ===== tb/tb_rmap_transaction_tracker.sv =====
`default_nettype none

module tb_rmap_transaction_tracker;
    timeunit 1ns;
    timeprecision 1ps;

    import rmap_tt_pkg::*;

    localparam int unsigned TID_LIMIT   = 65535;
    localparam int          ISSUE_BURST = 40;
    localparam int          MIXED_ITEMS = 1400;
    localparam int          HOLD_CYCLES = 300;
    localparam int          IDLE_LIMIT  = 3000;
    localparam int          DRAIN_WAIT  = 8;

    // Field values the package leaves unnamed
    localparam logic [1:0] LINK_NO_CONNECT = 2'd2;
    localparam logic [1:0] LINK_UNDEFINED  = 2'd3;
    localparam logic [1:0] TX_LINK_ERR     = 2'd2;
    localparam logic [1:0] TX_UNDEFINED    = 2'd3;
    localparam logic [1:0] KIND_OTHER      = 2'd0;
    localparam logic [1:0] KIND_UNDEFINED  = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        out_stall = 1'b0;
    item_t       cmd = '0;
    logic        in_stall;
    logic        out_valid;
    logic [4:0]  status;
    logic [15:0] current_tid;

    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    logic        squeeze_req = 1'b0;
    int          items_sent = 0;
    int          quiet_cycles;
    int          fail_count;
    int          outstanding;
    logic [15:0] model_tid;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    rmap_transaction_tracker #(
        .TID_MAX(TID_LIMIT)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (cmd.mode),
        .request_ack   (cmd.request_ack),
        .request_len   (cmd.request_len),
        .link_result   (cmd.link_result),
        .tx_state      (cmd.tx_state),
        .rx_ended      (cmd.rx_ended),
        .rx_error_flags(cmd.rx_error_flags),
        .reply_parsed  (cmd.reply_parsed),
        .reply_kind    (cmd.reply_kind),
        .reply_tid     (cmd.reply_tid),
        .reply_status  (cmd.reply_status),
        .reply_len     (cmd.reply_len),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .current_tid   (current_tid)
    );

    rmap_tt_checker #(
        .TID_MAX(TID_LIMIT)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req        (cmd),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .current_tid(current_tid),
        .fail_count (fail_count),
        .outstanding(outstanding),
        .model_tid  (model_tid)
    );

    // Result side: random stalls, plus one long hold-off to back up the block
    initial
    begin : receiver
        int hold_left;
        bit squeeze_done;
        hold_left    = 0;
        squeeze_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (squeeze_req && !squeeze_done)
            begin
                hold_left    = HOLD_CYCLES;
                squeeze_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    // Abort when neither channel moves for too long
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("Regression FAIL");
        $finish;
    end

    // Random bits across the whole item
    function automatic item_t noise_item();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return raw[$bits(item_t)-1:0];
    endfunction

    // Offer one item from a falling edge and hold it until taken
    task automatic send_item(input item_t it);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= it;
        @(posedge clk);
        while (!(in_valid && !in_stall))
        begin
            @(posedge clk);
        end
        items_sent++;
        @(negedge clk);
    endtask

    // Issue, or link reset when mode says so; unused fields stay random
    task automatic command(input logic [1:0] m, input logic ack, input logic [23:0] len,
                           input logic [1:0] link);
        item_t it;
        it             = noise_item();
        it.mode        = m;
        it.request_ack = ack;
        it.request_len = len;
        it.link_result = link;
        send_item(it);
    endtask

    task automatic poll(input logic [1:0] tx, input logic ended, input logic [3:0] flags,
                        input logic parsed, input logic [1:0] kind, input logic [15:0] tid,
                        input logic [7:0] rstat, input logic [23:0] rlen);
        item_t it;
        it                = noise_item();
        it.mode           = MODE_POLL;
        it.tx_state       = tx;
        it.rx_ended       = ended;
        it.rx_error_flags = flags;
        it.reply_parsed   = parsed;
        it.reply_kind     = kind;
        it.reply_tid      = tid;
        it.reply_status   = rstat;
        it.reply_len      = rlen;
        send_item(it);
    endtask

    // Mostly a clean reply to the tracked command, with occasional damage
    task automatic reply_poll(input logic [1:0] tx, input logic rd, input logic [23:0] len);
        logic [3:0]  flags;
        logic [1:0]  kind;
        logic [15:0] tid;
        logic [7:0]  rstat;
        logic [23:0] rlen;
        flags = ($urandom_range(9) == 0) ? 4'($urandom_range(1, 15)) : 4'h0;
        kind  = ($urandom_range(9) == 0) ? 2'($urandom)
                                         : (rd ? KIND_READ_REPLY : KIND_WRITE_REPLY);
        tid   = ($urandom_range(9) == 0) ? 16'($urandom) : model_tid;
        case ($urandom_range(7))
            0:       rstat = 8'($urandom);
            1:       rstat = 8'($urandom_range(1, 12));
            default: rstat = '0;
        endcase
        rlen  = ($urandom_range(9) == 0) ? 24'($urandom) : len;
        poll(tx, 1'b1, flags, ($urandom_range(19) != 0), kind, tid, rstat, rlen);
    endtask

    // One command from issue to resolution
    task automatic one_transaction();
        logic        rd;
        logic [23:0] len;
        logic [1:0]  tx;
        item_t       it;
        rd = 1'($urandom);
        case ($urandom_range(3))
            0:       len = '0;
            1:       len = '1;
            default: len = 24'($urandom);
        endcase
        command(rd ? MODE_READ : MODE_WRITE, 1'($urandom), len,
                ($urandom_range(9) == 0) ? 2'($urandom) : LINK_RUNNING);
        repeat ($urandom_range(2))
        begin
            it          = noise_item();
            it.mode     = MODE_POLL;
            it.tx_state = TX_BUSY;
            send_item(it);
        end
        tx = ($urandom_range(19) == 0) ? 2'($urandom_range(TX_LINK_ERR, TX_UNDEFINED))
                                       : TX_DONE;
        // Either resolve transmit and reply in one poll, or wait on the reply
        if ($urandom_range(2) != 0)
        begin
            it          = noise_item();
            it.mode     = MODE_POLL;
            it.tx_state = tx;
            it.rx_ended = 1'b0;
            send_item(it);
            repeat ($urandom_range(2))
            begin
                it          = noise_item();
                it.mode     = MODE_POLL;
                it.rx_ended = 1'b0;
                send_item(it);
            end
        end
        reply_poll(tx, rd, len);
        if ($urandom_range(4) == 0)
        begin
            send_item(noise_item());
        end
    endtask

    // Mix clean transactions with noise until the count is reached
    task automatic run_transactions(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target)
        begin
            if ($urandom_range(99) < 20)
            begin
                repeat ($urandom_range(1, 3)) send_item(noise_item());
            end
            else
            begin
                one_transaction();
            end
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        tx_idle_pct = 24;
        rx_idle_pct = 74;

        // Poll and link reset while disconnected, then failed issues
        poll(TX_BUSY, 1'b0, 4'h0, 1'b0, KIND_OTHER, 16'h0000, 8'h00, 24'h000000);
        command(MODE_LINK, 1'b0, 24'h000000, LINK_UNDEFINED);
        command(MODE_WRITE, 1'b1, 24'hFFFFFF, LINK_INIT_FAILED);
        command(MODE_READ, 1'b0, 24'h000000, LINK_NO_CONNECT);
        command(MODE_LINK, 1'b0, 24'h000000, LINK_RUNNING);

        // Write without ack: link outcome ignored when idle, done goes straight to ok
        command(MODE_WRITE, 1'b0, 24'hFFFFFF, LINK_UNDEFINED);
        poll(TX_BUSY, 1'b1, 4'hF, 1'b1, KIND_UNDEFINED, 16'hFFFF, 8'hFF, 24'hFFFFFF);
        poll(TX_DONE, 1'b0, 4'h0, 1'b0, KIND_OTHER, 16'h0000, 8'h00, 24'h000000);
        poll(TX_DONE, 1'b1, 4'h0, 1'b1, KIND_WRITE_REPLY, model_tid, 8'h00, 24'h000000);

        // Undefined transmit state, then reply flags and a repeated poll after failure
        command(MODE_READ, 1'b0, 24'hFFFFFF, LINK_RUNNING);
        poll(TX_UNDEFINED, 1'b0, 4'h0, 1'b1, KIND_READ_REPLY, model_tid, 8'h00, 24'hFFFFFF);
        command(MODE_READ, 1'b0, 24'h000123, LINK_RUNNING);
        poll(TX_DONE, 1'b0, 4'h0, 1'b1, KIND_READ_REPLY, model_tid, 8'h00, 24'h000123);
        poll(TX_BUSY, 1'b1, 4'hF, 1'b1, KIND_READ_REPLY, model_tid, 8'h00, 24'h000123);
        poll(TX_BUSY, 1'b1, 4'h8, 1'b1, KIND_READ_REPLY, model_tid, 8'h00, 24'h000123);

        // Undefined reply kind in a combined poll
        command(MODE_WRITE, 1'b1, 24'h000000, LINK_RUNNING);
        poll(TX_DONE, 1'b1, 4'h0, 1'b1, KIND_UNDEFINED, model_tid, 8'h00, 24'h000000);

        // Issue while sending drops the old command; length check on a read
        command(MODE_WRITE, 1'b1, 24'h000005, LINK_RUNNING);
        command(MODE_READ, 1'b0, 24'h000007, LINK_RUNNING);
        poll(TX_DONE, 1'b1, 4'h0, 1'b1, KIND_READ_REPLY, model_tid, 8'h00, 24'h000008);

        // Remote status eight, above twelve, and the last mapped value
        command(MODE_READ, 1'b0, 24'h000009, LINK_RUNNING);
        poll(TX_DONE, 1'b1, 4'h0, 1'b1, KIND_READ_REPLY, model_tid, 8'd8, 24'h000008);
        command(MODE_WRITE, 1'b1, 24'h000000, LINK_RUNNING);
        poll(TX_DONE, 1'b1, 4'h0, 1'b1, KIND_WRITE_REPLY, model_tid, 8'hFF, 24'hFFFFFF);
        command(MODE_WRITE, 1'b1, 24'h000000, LINK_RUNNING);
        poll(TX_DONE, 1'b1, 4'h0, 1'b1, KIND_WRITE_REPLY, model_tid, 8'd12, 24'h000000);

        // Id mismatch, then a clean read
        command(MODE_READ, 1'b0, 24'h000042, LINK_RUNNING);
        poll(TX_DONE, 1'b1, 4'h0, 1'b1, KIND_READ_REPLY, ~model_tid, 8'h00, 24'h000042);
        command(MODE_READ, 1'b0, 24'h000042, LINK_RUNNING);
        poll(TX_DONE, 1'b1, 4'h0, 1'b1, KIND_READ_REPLY, model_tid, 8'h00, 24'h000042);

        // Random traffic under three idling mixes
        run_transactions(MIXED_ITEMS / 3);
        tx_idle_pct = 74;
        rx_idle_pct = 24;
        run_transactions(MIXED_ITEMS / 3);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        squeeze_req = 1'b1;
        run_transactions(MIXED_ITEMS / 3);

        // Back-to-back issues, each one dropping the command before it
        repeat (ISSUE_BURST)
        begin
            command($urandom_range(1) ? MODE_READ : MODE_WRITE, 1'($urandom),
                    24'($urandom), LINK_RUNNING);
        end

        in_valid <= 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_WAIT) @(negedge clk);

        if (fail_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/rmap_tt_pkg.sv
rtl/core/rmap_tt_poll.sv
rtl/core/rmap_tt_core.sv
rtl/core/rmap_transaction_tracker.sv
tb/rmap_tt_checker.sv
tb/tb_rmap_transaction_tracker.sv
